// ----- rtl/core/tql_pkg.sv -----
`timescale 1ns / 1ps

package tql_pkg;

    // table geometry
    localparam int STATES  = 4;
    localparam int ACTIONS = 4;
    localparam int ROW_W   = (STATES > 1) ? $clog2(STATES) : 1;
    localparam int COL_W   = (ACTIONS > 1) ? $clog2(ACTIONS) : 1;
    localparam int ADDR_W  = $clog2(STATES * ACTIONS);
    localparam int TIE_W   = $clog2(ACTIONS + 1);

    // item field widths
    localparam int IDX_W    = 2;
    localparam int Q_W      = 32;
    localparam int DRAW_W   = 16;
    localparam int RATE_W   = 17;
    localparam int FRAC_W   = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 40;

    // datapath widths
    localparam int D_W    = 35;
    localparam int PROD_W = RATE_W + 1 + D_W;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_RATE = 2'd2;

    localparam logic [RATE_W-1:0] ONE_Q16           = 17'd65536;
    localparam logic [RATE_W-1:0] LEARN_RATE_RESET  = 17'd13107;
    localparam logic [RATE_W-1:0] DISCOUNT_RESET    = 17'd58982;
    localparam logic [RATE_W-1:0] EXPLORE_RATE_RESET = 17'd9830;

    // operation codes
    localparam logic OP_CHOOSE = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_QREAD,
        ST_MUL_G,
        ST_DIFF,
        ST_MUL_A,
        ST_WRITE,
        ST_OUT
    } tql_state_t;

    function automatic logic [RATE_W-1:0] clamp_one(input logic [RATE_W-1:0] r);
        clamp_one = (r > ONE_Q16) ? ONE_Q16 : r;
    endfunction

endpackage

// ----- rtl/core/tabular_q_learning_agent.sv -----
`timescale 1ns / 1ps
// explore choose reads the drawn entry; greedy choose scans the row through the
// single table read port, then walks it again for the drawn tie; update scans the
// next row, reads the entry, then takes the gamma product, the difference and the
// alpha product on the shared multiplier and writes back; one item at a time, and a
// result not yet taken holds the next item in its output step
// reset (rst_n low, asynchronous) clears the table to zero and loads the rate defaults
module tabular_q_learning_agent (
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: state_index[1:0], action_index[3:2], reward[35:4],
    //        next_state_index[37:36], explore_draw[53:38], pick_draw[69:54]
    input  logic [tql_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: action (0 choose, 1 update)
    input  logic                           s_axis_tuser,
    // result items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: chosen_action[1:0], q_value[33:2]
    output logic [tql_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: explored
    output logic                           m_axis_tuser,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tql_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tql_pkg::RATE_W-1:0]     cfg_data
);
    import tql_pkg::*;

    // input field slices
    logic [IDX_W-1:0]    in_state;
    logic [IDX_W-1:0]    in_col;
    logic [Q_W-1:0]      in_reward;
    logic [IDX_W-1:0]    in_next_state;
    logic [DRAW_W-1:0]   in_explore_draw;
    logic [DRAW_W-1:0]   in_pick_draw;

    assign in_state        = s_axis_tdata[1:0];
    assign in_col          = s_axis_tdata[3:2];
    assign in_reward       = s_axis_tdata[35:4];
    assign in_next_state   = s_axis_tdata[37:36];
    assign in_explore_draw = s_axis_tdata[53:38];
    assign in_pick_draw    = s_axis_tdata[69:54];

    // configuration registers, always ready
    logic [RATE_W-1:0] learn_rate_reg;
    logic [RATE_W-1:0] discount_reg;
    logic [RATE_W-1:0] explore_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg   <= LEARN_RATE_RESET;
            discount_reg     <= DISCOUNT_RESET;
            explore_rate_reg <= EXPLORE_RATE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEARN_RATE:   learn_rate_reg   <= cfg_data;
                REG_DISCOUNT:     discount_reg     <= cfg_data;
                REG_EXPLORE_RATE: explore_rate_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // sequencer and datapath registers
    tql_state_t               state_reg, state_next;
    logic                     op_reg, op_next;
    logic [ROW_W-1:0]         row_reg, row_next;
    logic [ROW_W-1:0]         next_row_reg, next_row_next;
    logic [COL_W-1:0]         col_reg, col_next;
    logic signed [Q_W-1:0]    reward_reg, reward_next;
    logic [DRAW_W-1:0]        pick_draw_reg, pick_draw_next;
    logic                     explored_reg, explored_next;
    logic [COL_W-1:0]         idx_reg, idx_next;
    logic [TIE_W-1:0]         cnt_reg, cnt_next;
    logic [TIE_W-1:0]         ties_reg, ties_next;
    logic signed [Q_W-1:0]    best_reg, best_next;
    logic signed [Q_W-1:0]    q_reg, q_next;
    logic signed [D_W-1:0]    d_reg, d_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic [COL_W-1:0]         out_act_reg, out_act_next;
    logic                     out_expl_reg, out_expl_next;
    logic signed [Q_W-1:0]    out_q_reg, out_q_next;

    // value table: one read and one write address a cycle
    logic signed [Q_W-1:0]    tbl_reg [STATES*ACTIONS];
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     wr_en;
    logic signed [Q_W-1:0]    wr_data;
    logic signed [Q_W-1:0]    rd_data;
    logic [ROW_W-1:0]         rd_row;
    logic [COL_W-1:0]         rd_col;

    assign rd_addr = ADDR_W'(rd_row * ACTIONS + rd_col);
    assign wr_addr = ADDR_W'(row_reg * ACTIONS + col_reg);
    assign rd_data = tbl_reg[rd_addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STATES * ACTIONS; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            tbl_reg[wr_addr] <= wr_data;
        end
    end

    // shared multiplier: gamma * max(next row), then alpha * difference
    logic [RATE_W-1:0]        mul_a;
    logic signed [D_W-1:0]    mul_b;
    logic signed [PROD_W-1:0] mul_p;

    assign mul_a = (state_reg == ST_MUL_G) ? clamp_one(discount_reg) : clamp_one(learn_rate_reg);
    assign mul_b = (state_reg == ST_MUL_G) ? D_W'(best_reg) : d_reg;
    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // floor shift of the registered product
    logic signed [PROD_W-1:0] prod_shr;
    logic signed [D_W-1:0]    prod_term;
    logic signed [D_W-1:0]    diff;
    logic signed [D_W-1:0]    new_sum;
    logic signed [Q_W-1:0]    new_q;

    assign prod_shr  = prod_reg >>> FRAC_W;
    assign prod_term = D_W'(prod_shr);
    assign diff      = D_W'(reward_reg) + prod_term - D_W'(q_reg);
    assign new_sum   = D_W'(q_reg) + prod_term;

    // saturate to 32 bits signed
    always_comb
    begin
        if (new_sum > D_W'(35'sh0_7FFF_FFFF))
            new_q = 32'sh7FFF_FFFF;
        else if (new_sum < -D_W'(35'sh0_8000_0000))
            new_q = 32'sh8000_0000;
        else
            new_q = Q_W'(new_sum);
    end

    // random action and tied-action rank
    logic [DRAW_W+COL_W:0]    explore_prod;
    logic [DRAW_W+TIE_W-1:0]  tie_prod;
    logic [TIE_W-1:0]         tie_rank;
    logic                     explore_hit;
    logic                     scan_last;

    assign explore_prod = in_pick_draw * (COL_W+1)'(ACTIONS);
    assign tie_prod     = pick_draw_reg * ties_reg;
    assign tie_rank     = tie_prod[DRAW_W +: TIE_W];
    assign explore_hit  = {1'b0, in_explore_draw} < explore_rate_reg;
    assign scan_last    = (idx_reg == COL_W'(ACTIONS - 1));

    assign s_axis_tready = (state_reg == ST_IDLE);

    // next state and datapath
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        row_next       = row_reg;
        next_row_next  = next_row_reg;
        col_next       = col_reg;
        reward_next    = reward_reg;
        pick_draw_next = pick_draw_reg;
        explored_next  = explored_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        ties_next      = ties_reg;
        best_next      = best_reg;
        q_next         = q_reg;
        d_next         = d_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_act_next   = out_act_reg;
        out_expl_next  = out_expl_reg;
        out_q_next     = out_q_reg;
        wr_en          = 1'b0;
        wr_data        = new_q;
        rd_row         = row_reg;
        rd_col         = col_reg;

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next        = s_axis_tuser;
                    row_next       = ROW_W'(in_state % STATES);
                    next_row_next  = ROW_W'(in_next_state % STATES);
                    reward_next    = $signed(in_reward);
                    pick_draw_next = in_pick_draw;
                    idx_next       = '0;
                    cnt_next       = '0;
                    explored_next  = 1'b0;
                    col_next       = COL_W'(in_col % ACTIONS);
                    if (s_axis_tuser == OP_CHOOSE && explore_hit)
                    begin
                        explored_next = 1'b1;
                        col_next      = explore_prod[DRAW_W +: COL_W];
                        state_next    = ST_QREAD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // row maximum and tie count, one entry a cycle
            ST_SCAN:
            begin
                rd_row = (op_reg == OP_UPDATE) ? next_row_reg : row_reg;
                rd_col = idx_reg;
                if (idx_reg == '0 || rd_data > best_reg)
                begin
                    best_next = rd_data;
                    ties_next = TIE_W'(1);
                end
                else if (rd_data == best_reg)
                begin
                    ties_next = ties_reg + TIE_W'(1);
                end
                idx_next = idx_reg + COL_W'(1);
                if (scan_last)
                begin
                    idx_next   = '0;
                    state_next = (op_reg == OP_UPDATE) ? ST_QREAD : ST_PICK;
                end
            end

            // walk the row again for the tied entry of the drawn rank
            ST_PICK:
            begin
                rd_row   = row_reg;
                rd_col   = idx_reg;
                idx_next = idx_reg + COL_W'(1);
                if (rd_data == best_reg)
                begin
                    if (cnt_reg == tie_rank)
                    begin
                        col_next   = idx_reg;
                        q_next     = best_reg;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + TIE_W'(1);
                    end
                end
            end

            ST_QREAD:
            begin
                rd_row     = row_reg;
                rd_col     = col_reg;
                q_next     = rd_data;
                state_next = (op_reg == OP_UPDATE) ? ST_MUL_G : ST_OUT;
            end

            ST_MUL_G:
            begin
                prod_next  = mul_p;
                state_next = ST_DIFF;
            end

            ST_DIFF:
            begin
                d_next     = diff;
                state_next = ST_MUL_A;
            end

            ST_MUL_A:
            begin
                prod_next  = mul_p;
                state_next = ST_WRITE;
            end

            ST_WRITE:
            begin
                wr_en      = 1'b1;
                q_next     = new_q;
                state_next = ST_OUT;
            end

            // hand over to the output register once it is free
            ST_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_act_next   = col_reg;
                    out_expl_next  = explored_reg;
                    out_q_next     = q_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        row_reg       <= row_next;
        next_row_reg  <= next_row_next;
        col_reg       <= col_next;
        reward_reg    <= reward_next;
        pick_draw_reg <= pick_draw_next;
        explored_reg  <= explored_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        ties_reg      <= ties_next;
        best_reg      <= best_next;
        q_reg         <= q_next;
        d_reg         <= d_next;
        prod_reg      <= prod_next;
        out_act_reg   <= out_act_next;
        out_expl_reg  <= out_expl_next;
        out_q_reg     <= out_q_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_expl_reg;
    assign m_axis_tdata  = {(OUT_DATA_W-IDX_W-Q_W)'(0), out_q_reg, IDX_W'(out_act_reg)};

endmodule
